FILE: sv/ascending_integer_sorter_defines.svh
// ----------------------------------------------------------------------------
// ascending_integer_sorter_defines.svh
// assertion macros used by the sorter top level
// ----------------------------------------------------------------------------
`ifndef ASCENDING_INTEGER_SORTER_DEFINES_SVH
`define ASCENDING_INTEGER_SORTER_DEFINES_SVH

// same-cycle implication under reset
`define AIS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define AIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ais_pkg.sv
// ----------------------------------------------------------------------------
// ais_pkg
// shared constants and types of the ascending integer sorter
// ----------------------------------------------------------------------------
package ais_pkg;

    localparam int AIS_DATA_W   = 32;
    localparam int AIS_CAPACITY = 64;

    // per-cycle command to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // what a cell shows its right neighbor
    typedef struct packed {
        logic signed [AIS_DATA_W-1:0] value;
        logic                         occ;
        logic                         gt;
    } cell_link_t;

endpackage

FILE: sv/ais_if.sv
// ----------------------------------------------------------------------------
// ais_if
// valid/ready stream interfaces for sorter input and result beats
// ----------------------------------------------------------------------------
interface ais_in_if;
    import ais_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [AIS_DATA_W-1:0] sample;
    logic                         batch_end;

    modport source (output valid, output sample, output batch_end, input ready);
    modport sink   (input valid, input sample, input batch_end, output ready);
endinterface

interface ais_out_if;
    import ais_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [AIS_DATA_W-1:0] sorted_value;
    logic                         final_result;
    logic                         dropped_flag;

    modport source (output valid, output sorted_value, output final_result,
                    output dropped_flag, input ready);
    modport sink   (input valid, input sorted_value, input final_result,
                    input dropped_flag, output ready);
endinterface

FILE: sv/ais_cell.sv
// ----------------------------------------------------------------------------
// ais_cell
// one slot of the insertion chain: compare, take from left, new or right
// ----------------------------------------------------------------------------
module ais_cell import ais_pkg::*;
(
    input  logic                         clk,
    input  cell_ctrl_t                   ctrl,
    input  logic signed [AIS_DATA_W-1:0] sample,
    input  logic                         occ,
    input  cell_link_t                   left,
    input  logic signed [AIS_DATA_W-1:0] right_value,
    output cell_link_t                   link
);

    logic signed [AIS_DATA_W-1:0] value_reg;
    logic signed [AIS_DATA_W-1:0] value_next;
    logic                         gt;

    // new value goes after equal ones, so strict compare
    assign gt = occ && (value_reg > sample);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert)
        begin
            if (left.gt)
            begin
                value_next = left.value;
            end
            else if (left.occ && (gt || !occ))
            begin
                value_next = sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.occ   = occ;
    assign link.gt    = gt;

endmodule

FILE: sv/ascending_integer_sorter.sv
// ----------------------------------------------------------------------------
// ascending_integer_sorter
// batch sorter built as a chain of insertion cells
// ----------------------------------------------------------------------------
// Collects a batch of signed 32-bit samples, one beat per cycle, into a row
// of CAPACITY cells kept in ascending order; every cell compares its value
// with the incoming sample in parallel and shifts right by one where needed.
// The beat flagged batch_end also belongs to the batch. After it the input
// stalls and the chain shifts left one cell per accepted result beat,
// sending the batch out in ascending order with final_result on the last
// beat. Samples that arrive while all cells are full are dropped and every
// result beat of that batch carries dropped_flag. Equal samples are all
// kept, a later one behind the earlier ones.
// ----------------------------------------------------------------------------
`include "ascending_integer_sorter_defines.svh"

module ascending_integer_sorter import ais_pkg::*;
#(
    parameter int CAPACITY = AIS_CAPACITY
)
(
    input  logic         clk,
    input  logic         rst_n,
    ais_in_if.sink       feed,
    ais_out_if.source    sorted
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // control state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             draining_reg;
    logic             draining_next;
    logic             overflow_reg;
    logic             overflow_next;

    logic             in_fire;
    logic             out_fire;
    logic             full;
    cell_ctrl_t       ctrl;

    cell_link_t       links [CAPACITY];

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign in_fire  = feed.valid && feed.ready;
    assign out_fire = sorted.valid && sorted.ready;

    // input held off for the whole drain
    assign feed.ready = !draining_reg;

    // insert only with room left; shift left on each result beat
    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = out_fire;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_link_t                   left_link;
        logic signed [AIS_DATA_W-1:0] right_value;
        logic                         occ;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            // head sees an occupied, never-greater neighbor
            assign left_link = '{value: '0, occ: 1'b1, gt: 1'b0};
        end
        else
        begin : g_body
            assign left_link = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = links[i].value;
        end
        else
        begin : g_inner
            assign right_value = links[i+1].value;
        end

        ais_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .sample      (feed.sample),
            .occ         (occ),
            .left        (left_link),
            .right_value (right_value),
            .link        (links[i])
        );
    end

    // control next state
    always_comb
    begin
        count_next    = count_reg;
        draining_next = draining_reg;
        overflow_next = overflow_reg;
        if (in_fire)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (feed.batch_end)
            begin
                draining_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                // last beat out: ready for the next batch
                draining_next = 1'b0;
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            draining_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
        end
    end

    // results come straight from the head cell register
    assign sorted.valid        = draining_reg && (count_reg != '0);
    assign sorted.sorted_value = links[0].value;
    assign sorted.final_result = (count_reg == CNT_W'(1));
    assign sorted.dropped_flag = overflow_reg;

    // a drain always has something to send
    `AIS_ASSERT_NOW(a_drain_nonempty, clk, rst_n, draining_reg, count_reg != '0,
        "drain with empty chain")

    // occupancy never passes the number of cells
    `AIS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "count above capacity")

    // head of the chain is the smallest of the first two
    `AIS_ASSERT_NOW(a_head_order, clk, rst_n, count_reg >= CNT_W'(2),
        links[0].value <= links[1].value, "chain out of order")

    // a full chain turns any new sample into an overflow
    `AIS_ASSERT_NEXT(a_drop_flags, clk, rst_n, in_fire && full, overflow_reg,
        "dropped sample not flagged")

    // the final beat leaves the block empty and collecting
    `AIS_ASSERT_NEXT(a_final_clears, clk, rst_n, out_fire && sorted.final_result,
        !draining_reg && (count_reg == '0) && !overflow_reg, "batch not cleared")

endmodule
